/* design/hst_pkg.sv */
// Shared types and codes for the handle slot table.
// Used by hst_ctrl, hst_dp and handle_slot_table; depends on nothing.
package hst_pkg;

  localparam int DEF_CAPACITY = 256;

  // Live bits are kept 32 to a bitmap word.
  localparam int WORD_BITS  = 32;
  localparam int WORD_SHIFT = 5;

  // Operation codes (mode field)
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_BAD_HANDLE = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] handle;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] result_handle;
    logic [7:0] position;
    logic       moved;
    logic [7:0] moved_from;
    logic [7:0] moved_handle;
    logic [8:0] live_count;
  } res_t;

  // Controller to datapath
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_CLR_STEP,
    CMD_CLR_LAST,
    CMD_SCAN_RD,
    CMD_SCAN_CHK,
    CMD_FULL,
    CMD_LOOK_RD,
    CMD_LOOK_EX
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic word_free;
    logic clr_last;
  } sts_t;

endpackage

/* design/hst_ctrl.sv */
// Sequencer for the handle slot table.
// Depends on hst_pkg (cmd_t, sts_t, mode codes).
module hst_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [1:0]       mode,
  input  hst_pkg::sts_t    sts,
  output hst_pkg::cmd_t    cmd,
  output logic             busy
);

  typedef enum logic [2:0] {
    S_CLR_RST,
    S_CLR_OP,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_LOOK_RD,
    S_LOOK_EX
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = hst_pkg::CMD_NONE;
    unique case (state_r)
      S_CLR_RST: begin
        cmd = hst_pkg::CMD_CLR_STEP;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_CLR_OP: begin
        if (sts.clr_last) begin
          cmd       = hst_pkg::CMD_CLR_LAST;
          state_nxt = S_IDLE;
        end else begin
          cmd = hst_pkg::CMD_CLR_STEP;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd = hst_pkg::CMD_CAPTURE;
          unique case (mode)
            hst_pkg::MODE_ADD:   state_nxt = S_SCAN_RD;
            hst_pkg::MODE_CLEAR: state_nxt = S_CLR_OP;
            default:             state_nxt = S_LOOK_RD;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (sts.full) begin
          cmd       = hst_pkg::CMD_FULL;
          state_nxt = S_IDLE;
        end else begin
          cmd       = hst_pkg::CMD_SCAN_RD;
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        cmd       = hst_pkg::CMD_SCAN_CHK;
        state_nxt = sts.word_free ? S_IDLE : S_SCAN_RD;
      end
      S_LOOK_RD: begin
        cmd       = hst_pkg::CMD_LOOK_RD;
        state_nxt = S_LOOK_EX;
      end
      S_LOOK_EX: begin
        cmd       = hst_pkg::CMD_LOOK_EX;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR_RST;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

/* design/hst_dp.sv */
// Datapath of the handle slot table: live bitmap, both maps, entry count,
// free-handle scan and the result register. Depends on hst_pkg.
module hst_dp #(
  parameter int CAPACITY = hst_pkg::DEF_CAPACITY
) (
  input  logic            clk,
  input  logic            rst_n,
  input  hst_pkg::cmd_t   cmd,
  input  hst_pkg::req_t   in_item,
  output hst_pkg::sts_t   sts,
  output hst_pkg::res_t   out_item,
  output logic            out_strobe
);

  localparam int WB   = hst_pkg::WORD_BITS;
  localparam int BW   = hst_pkg::WORD_SHIFT;
  localparam int HW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int NW   = (CAPACITY + hst_pkg::WORD_BITS - 1) / hst_pkg::WORD_BITS;
  localparam int WIDX = (NW > 1) ? $clog2(NW) : 1;

  typedef logic [WB-1:0] word_t;

  // Memories
  word_t           bm_mem  [NW];        // live bit per handle
  logic [HW-1:0]   poh_mem [CAPACITY];  // position of handle
  logic [HW-1:0]   hap_mem [CAPACITY];  // handle at position

  // Registers
  hst_pkg::req_t   op_r, op_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [WIDX-1:0] base_r, base_nxt;       // lowest word that may hold a free handle
  logic [WIDX-1:0] scan_ptr_r, scan_ptr_nxt;
  logic [WIDX-1:0] clr_ptr_r, clr_ptr_nxt;
  word_t           bm_rd_r;
  logic [HW-1:0]   poh_rd_r;
  logic [HW-1:0]   hap_rd_r;
  hst_pkg::res_t   out_item_r, out_item_nxt;
  logic            out_strobe_r, out_strobe_nxt;

  // Memory port controls
  logic            bm_re, bm_we, poh_re, poh_we, hap_re, hap_we;
  logic [WIDX-1:0] bm_ra, bm_wa;
  word_t           bm_wd;
  logic [HW-1:0]   poh_ra, poh_wa, poh_wd, hap_ra, hap_wa, hap_wd;

  // Decode
  logic [HW-1:0]   h_idx;
  logic [WIDX-1:0] h_word;
  logic [BW-1:0]   h_bit;
  logic            in_range;
  logic            live;
  logic [HW-1:0]   last_pos;
  logic [BW-1:0]   zero_bit;
  logic            word_free;
  logic [HW-1:0]   found;
  logic            full;
  logic            clr_last;

  assign h_idx    = HW'(op_r.handle);
  assign h_word   = WIDX'(h_idx >> BW);
  assign h_bit    = BW'(h_idx);
  assign in_range = int'(op_r.handle) < CAPACITY;
  assign live     = bm_rd_r[h_bit];
  assign last_pos = HW'(count_r - 1'b1);
  assign full     = (count_r == CW'(CAPACITY));
  assign clr_last = (clr_ptr_r == WIDX'(NW - 1));
  assign word_free = ~&bm_rd_r;

  // Lowest clear bit of the fetched bitmap word
  always_comb begin
    zero_bit = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (!bm_rd_r[i]) zero_bit = BW'(i);
    end
  end

  assign found = HW'({scan_ptr_r, zero_bit});

  always_comb begin
    op_nxt         = op_r;
    count_nxt      = count_r;
    base_nxt       = base_r;
    scan_ptr_nxt   = scan_ptr_r;
    clr_ptr_nxt    = clr_ptr_r;
    out_item_nxt   = out_item_r;
    out_strobe_nxt = 1'b0;
    bm_re  = 1'b0;  bm_ra  = scan_ptr_r;
    bm_we  = 1'b0;  bm_wa  = scan_ptr_r;  bm_wd = '0;
    poh_re = 1'b0;  poh_ra = h_idx;
    poh_we = 1'b0;  poh_wa = found;       poh_wd = HW'(count_r);
    hap_re = 1'b0;  hap_ra = last_pos;
    hap_we = 1'b0;  hap_wa = HW'(count_r); hap_wd = found;

    unique case (cmd)
      hst_pkg::CMD_NONE: begin
      end
      hst_pkg::CMD_CAPTURE: begin
        op_nxt       = in_item;
        scan_ptr_nxt = base_r;
      end
      hst_pkg::CMD_CLR_STEP,
      hst_pkg::CMD_CLR_LAST: begin
        bm_we       = 1'b1;
        bm_wa       = clr_ptr_r;
        bm_wd       = '0;
        clr_ptr_nxt = clr_last ? '0 : clr_ptr_r + 1'b1;
        count_nxt   = '0;
        base_nxt    = '0;
        if (cmd == hst_pkg::CMD_CLR_LAST) begin
          out_strobe_nxt      = 1'b1;
          out_item_nxt        = '0;
          out_item_nxt.status = hst_pkg::ST_OK;
        end
      end
      hst_pkg::CMD_FULL: begin
        out_strobe_nxt          = 1'b1;
        out_item_nxt            = '0;
        out_item_nxt.status     = hst_pkg::ST_FULL;
        out_item_nxt.live_count = 9'(count_r);
      end
      hst_pkg::CMD_SCAN_RD: begin
        bm_re = 1'b1;
        bm_ra = scan_ptr_r;
      end
      hst_pkg::CMD_SCAN_CHK: begin
        if (word_free) begin
          // take the handle: set live bit, link both maps, append
          bm_we     = 1'b1;
          bm_wa     = scan_ptr_r;
          bm_wd     = bm_rd_r | (word_t'(1) << zero_bit);
          poh_we    = 1'b1;
          hap_we    = 1'b1;
          count_nxt = count_r + 1'b1;
          base_nxt  = scan_ptr_r;
          out_strobe_nxt             = 1'b1;
          out_item_nxt               = '0;
          out_item_nxt.status        = hst_pkg::ST_OK;
          out_item_nxt.result_handle = 8'(found);
          out_item_nxt.position      = 8'(count_r);
          out_item_nxt.live_count    = 9'(count_r + 1'b1);
        end else begin
          scan_ptr_nxt = scan_ptr_r + 1'b1;
        end
      end
      hst_pkg::CMD_LOOK_RD: begin
        bm_re  = 1'b1;
        bm_ra  = h_word;
        poh_re = 1'b1;
        poh_ra = h_idx;
        hap_re = 1'b1;
        hap_ra = last_pos;
      end
      hst_pkg::CMD_LOOK_EX: begin
        out_strobe_nxt             = 1'b1;
        out_item_nxt               = '0;
        out_item_nxt.result_handle = op_r.handle;
        out_item_nxt.live_count    = 9'(count_r);
        if (!in_range || !live) begin
          out_item_nxt.status = hst_pkg::ST_BAD_HANDLE;
        end else if (op_r.mode == hst_pkg::MODE_LOOKUP) begin
          out_item_nxt.status   = hst_pkg::ST_OK;
          out_item_nxt.position = 8'(poh_rd_r);
        end else begin
          // delete: free the bit, fill the hole from the tail
          bm_we     = 1'b1;
          bm_wa     = h_word;
          bm_wd     = bm_rd_r & ~(word_t'(1) << h_bit);
          count_nxt = count_r - 1'b1;
          // a freed handle below the scan start moves the start down
          if (h_word < base_r) base_nxt = h_word;
          out_item_nxt.status     = hst_pkg::ST_OK;
          out_item_nxt.position   = 8'(poh_rd_r);
          out_item_nxt.live_count = 9'(count_r - 1'b1);
          if (poh_rd_r != last_pos) begin
            hap_we = 1'b1;
            hap_wa = poh_rd_r;
            hap_wd = hap_rd_r;
            poh_we = 1'b1;
            poh_wa = hap_rd_r;
            poh_wd = poh_rd_r;
            out_item_nxt.moved        = 1'b1;
            out_item_nxt.moved_from   = 8'(last_pos);
            out_item_nxt.moved_handle = 8'(hap_rd_r);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Memories: one write and one registered read each per cycle
  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_wa] <= bm_wd;
    if (bm_re) bm_rd_r <= bm_mem[bm_ra];
  end

  always_ff @(posedge clk) begin
    if (poh_we) poh_mem[poh_wa] <= poh_wd;
    if (poh_re) poh_rd_r <= poh_mem[poh_ra];
  end

  always_ff @(posedge clk) begin
    if (hap_we) hap_mem[hap_wa] <= hap_wd;
    if (hap_re) hap_rd_r <= hap_mem[hap_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      base_r       <= '0;
      scan_ptr_r   <= '0;
      clr_ptr_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      base_r       <= base_nxt;
      scan_ptr_r   <= scan_ptr_nxt;
      clr_ptr_r    <= clr_ptr_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    out_item_r <= out_item_nxt;
  end

  assign sts.full      = full;
  assign sts.word_free = word_free;
  assign sts.clr_last  = clr_last;
  assign out_item      = out_item_r;
  assign out_strobe    = out_strobe_r;

endmodule

/* design/handle_slot_table.sv */
// Top level of the handle slot table: controller plus datapath.
// Depends on hst_pkg, hst_ctrl and hst_dp.
//
// Handle slot table. Keeps a dense array of live entries and a handle to
// position map for up to CAPACITY handles. An operation is taken when start
// is high and busy is low; its single result appears for exactly one cycle
// with out_strobe high and cannot be stalled, so the receiver must take it
// then. Busy drops in the cycle the result is shown, so the next operation
// may be started while the previous result is on the ports. An add scans
// the bitmap from the lowest word that may hold a free handle and passes
// over 32-handle words that have none; an add to a full table reports
// ST_FULL without a scan. A delete or lookup reads the bitmap and both maps
// and then acts on the handle. A clear clears the bitmap word by word.
// The live bits sit in one bitmap memory of 32-bit words with one read and
// one write port, so the clearing of all handles goes one word per cycle,
// while the free-handle scan reads each word and checks it before it reads
// the next. After reset the block runs the same clear over every bitmap
// word with busy high before it takes its first operation. A delete reports
// the hole position and, when the tail entry moved into the hole, its old
// position and handle, so an outside payload store can mirror the move.
// Handles and positions wider than 8 bits are reported in their low 8 bits.
module handle_slot_table #(
  parameter int CAPACITY = hst_pkg::DEF_CAPACITY
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  hst_pkg::req_t  in_item,
  output logic           out_strobe,
  output hst_pkg::res_t  out_item
);

  hst_pkg::cmd_t cmd;
  hst_pkg::sts_t sts;

  // Sequencer: picks the step of each operation from mode and status.
  hst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_item.mode),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Tables, count, scan and result register.
  hst_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_item    (in_item),
    .sts        (sts),
    .out_item   (out_item),
    .out_strobe (out_strobe)
  );

endmodule
